FILE: hdl/tpid_pkg.sv
// Shared types and constants for the two-axis incremental PID tracker.
// No dependencies; the lane, merge, top level and testbench import this package.
`default_nettype none

package tpid_pkg;

	localparam int FIELD_W    = 16;
	localparam int GAIN_W     = 16;
	localparam int SERVO_W    = 20;
	localparam int CFG_IDX_W  = 3;
	localparam int FIFO_DEPTH = 8;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = PTR_W + 1;

	localparam logic [GAIN_W-1:0] KP_RESET = GAIN_W'(1638);
	localparam logic [GAIN_W-1:0] KI_RESET = GAIN_W'(1475);
	localparam logic [GAIN_W-1:0] KD_RESET = GAIN_W'(1638);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P   = 3'd0,
		REG_GAIN_I   = 3'd1,
		REG_GAIN_D   = 3'd2,
		REG_ORIGIN_X = 3'd3,
		REG_ORIGIN_Y = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kd;
	} gains_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] target_x;
		logic signed [FIELD_W-1:0] target_y;
		logic signed [FIELD_W-1:0] spot_x;
		logic signed [FIELD_W-1:0] spot_y;
	} in_beat_t;

	typedef struct packed {
		logic signed [SERVO_W-1:0] servo_x;
		logic signed [SERVO_W-1:0] servo_y;
		logic                      spot_reused;
	} out_beat_t;

	typedef struct packed {
		logic                      valid;
		logic signed [SERVO_W-1:0] servo;
	} lane_res_t;

endpackage

`default_nettype wire

FILE: hdl/tpid_stream_if.sv
// Valid/ready stream interface carrying one payload beat.
// Payload type is set per instance; used by the tracker top level and merge stage.
`default_nettype none

interface tpid_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/tpid_lane.sv
// One axis of the tracker: error history, three gain products, rounding and
// the saturating position accumulator. Depends on tpid_pkg.
`default_nettype none

module tpid_lane
	import tpid_pkg::*;
#(
	parameter int GAIN_FRAC_BITS = 14,
	parameter int POS_FRAC_BITS  = 12
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire gains_t                    gains,
	input  wire logic                      live,
	input  wire logic signed [FIELD_W-1:0] target,
	input  wire logic signed [FIELD_W-1:0] spot,
	input  wire logic                      spot_gone,
	input  wire logic                      home,
	input  wire logic signed [FIELD_W-1:0] origin,
	output lane_res_t                      res
);

	localparam int E_W     = FIELD_W + 1;
	localparam int D1_W    = E_W + 1;
	localparam int D2_W    = E_W + 2;
	localparam int PROD_W  = GAIN_W + 1 + D2_W;
	localparam int SUM_W   = PROD_W + 2;
	localparam int SH      = GAIN_FRAC_BITS - POS_FRAC_BITS;
	localparam int LSH     = (SH < 0) ? -SH : 0;
	localparam int RSH     = (SH > 0) ? SH : 0;
	localparam int DELTA_W = SUM_W + 1 + LSH;
	localparam int POS_W   = SERVO_W + POS_FRAC_BITS;
	localparam int NP_W    = ((POS_W > DELTA_W) ? POS_W : DELTA_W) + 1;

	logic signed [FIELD_W-1:0] last_spot_q, spot_sel;
	logic signed [E_W-1:0]     err, e1_q, e2_q, e_s1;
	logic signed [D1_W-1:0]    d1, d1_s1;
	logic signed [D2_W-1:0]    d2, d2_s1;
	logic signed [GAIN_W:0]    kp_s, ki_s, kd_s;
	logic signed [PROD_W-1:0]  p_s2, i_s2, d_s2;
	logic signed [SUM_W-1:0]   sum;
	logic signed [DELTA_W-1:0] sum_ext, delta, delta_s3;
	logic signed [NP_W-1:0]    np;
	logic signed [POS_W-1:0]   np_sat, pos_q;
	logic                      v_s1, v_s2, v_s3, v_s4;
	logic                      in_range;

	always_comb begin
		spot_sel = spot_gone ? last_spot_q : spot;
		err      = E_W'(target) - E_W'(spot_sel);
		d1       = D1_W'(err) - D1_W'(e1_q);
		d2       = D2_W'(err) - (D2_W'(e1_q) <<< 1) + D2_W'(e2_q);
		kp_s     = signed'({1'b0, gains.kp});
		ki_s     = signed'({1'b0, gains.ki});
		kd_s     = signed'({1'b0, gains.kd});
		sum      = SUM_W'(p_s2) + SUM_W'(i_s2) + SUM_W'(d_s2);
		sum_ext  = DELTA_W'(sum);
	end

	generate
		if (RSH > 0) begin : g_round
			localparam logic signed [DELTA_W-1:0] HALF = DELTA_W'(1) << (RSH - 1);
			assign delta = (sum_ext + HALF) >>> RSH;
		end else begin : g_scale
			assign delta = sum_ext <<< LSH;
		end
	endgenerate

	always_comb begin
		np       = NP_W'(pos_q) + NP_W'(delta_s3);
		in_range = (&np[NP_W-1:POS_W-1]) || ~(|np[NP_W-1:POS_W-1]);
		if (in_range) begin
			np_sat = np[POS_W-1:0];
		end else begin
			np_sat = {np[NP_W-1], {(POS_W-1){~np[NP_W-1]}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			e1_q        <= '0;
			e2_q        <= '0;
			last_spot_q <= '0;
			pos_q       <= '0;
		end else begin
			v_s1 <= live;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (live) begin
				e1_q        <= err;
				e2_q        <= e1_q;
				last_spot_q <= spot_sel;
			end
			if (home) begin
				last_spot_q <= origin;
				pos_q       <= POS_W'(origin) <<< POS_FRAC_BITS;
			end else if (v_s3) begin
				pos_q <= np_sat;
			end
		end
	end

	always_ff @(posedge clk) begin
		e_s1     <= err;
		d1_s1    <= d1;
		d2_s1    <= d2;
		p_s2     <= kp_s * d1_s1;
		i_s2     <= ki_s * e_s1;
		d_s2     <= kd_s * d2_s1;
		delta_s3 <= delta;
	end

	always_comb begin
		res.valid = v_s4;
		res.servo = pos_q[POS_W-1:POS_FRAC_BITS];
	end

endmodule

`default_nettype wire

FILE: hdl/tpid_merge.sv
// Merge stage: joins both lane results and the reuse flag into one beat and
// queues it for the result channel. Depends on tpid_pkg and tpid_stream_if.
`default_nettype none

module tpid_merge
	import tpid_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire lane_res_t  lane_x,
	input  wire lane_res_t  lane_y,
	input  wire logic       reused,
	tpid_stream_if.source   servo
);

	out_beat_t        mem [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             wr, rd;

	always_comb begin
		wr          = lane_x.valid;
		rd          = (cnt_q != '0) && servo.ready;
		servo.valid = (cnt_q != '0);
		servo.data  = mem[rd_ptr_q];
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[wr_ptr_q] <= '{servo_x: lane_x.servo, servo_y: lane_y.servo,
				spot_reused: reused};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (rd) rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			cnt_q <= cnt_q + CNT_W'(wr) - CNT_W'(rd);
		end
	end

endmodule

`default_nettype wire

FILE: hdl/two_axis_incremental_pid_tracker.sv
// Top level of the two-axis incremental PID tracker: config registers, point
// screening, two axis lanes and the merge queue. Depends on tpid_pkg,
// tpid_stream_if, tpid_lane and tpid_merge.
//
//   channel   dir   beat                                   handshake
//   points    in    target_x, target_y, spot_x, spot_y     valid/ready
//   servo     out   servo_x, servo_y, spot_reused          valid/ready
//   cfg       in    cfg_index, cfg_data                    cfg_we
//
// One point beat per cycle sustained while ready is high; a result is offered once its
// point beat has passed the 4 lane stages and entered the merge queue.
// Points with a target at the origin are taken and give no result.
// Ready drops once 8 results are in flight or queued; the 8-entry merge queue
// absorbs result-side stalls. Reset loads the gain defaults and homes both axes.
`default_nettype none

module two_axis_incremental_pid_tracker
	import tpid_pkg::*;
#(
	parameter int COORD_WIDTH    = 16,
	parameter int GAIN_FRAC_BITS = 14,
	parameter int POS_FRAC_BITS  = 12
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	tpid_stream_if.sink               points,
	tpid_stream_if.source             servo,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [GAIN_W-1:0]    cfg_data
);

	gains_t                        gains_q;
	logic signed [COORD_WIDTH-1:0] tx_c, ty_c, sx_c, sy_c;
	logic signed [FIELD_W-1:0]     tx, ty, sx, sy;
	logic                          in_beat, out_beat, live, spot_gone;
	logic                          home_x, home_y;
	logic                          reused_s1, reused_s2, reused_s3, reused_s4;
	logic [CNT_W-1:0]              cnt_q;
	lane_res_t                     lane_x, lane_y;

	always_comb begin
		tx_c      = points.data.target_x[COORD_WIDTH-1:0];
		ty_c      = points.data.target_y[COORD_WIDTH-1:0];
		sx_c      = points.data.spot_x[COORD_WIDTH-1:0];
		sy_c      = points.data.spot_y[COORD_WIDTH-1:0];
		tx        = FIELD_W'(tx_c);
		ty        = FIELD_W'(ty_c);
		sx        = FIELD_W'(sx_c);
		sy        = FIELD_W'(sy_c);
		spot_gone = (sx_c == '0) && (sy_c == '0);

		points.ready = (cnt_q < CNT_W'(FIFO_DEPTH));
		in_beat      = points.valid && points.ready;
		out_beat     = servo.valid && servo.ready;
		live         = in_beat && !((tx_c == '0) && (ty_c == '0));

		home_x = cfg_we && (cfg_reg_t'(cfg_index) == REG_ORIGIN_X);
		home_y = cfg_we && (cfg_reg_t'(cfg_index) == REG_ORIGIN_Y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.kp <= KP_RESET;
			gains_q.ki <= KI_RESET;
			gains_q.kd <= KD_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GAIN_P: gains_q.kp <= cfg_data;
				REG_GAIN_I: gains_q.ki <= cfg_data;
				REG_GAIN_D: gains_q.kd <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CNT_W'(live) - CNT_W'(out_beat);
		end
	end

	always_ff @(posedge clk) begin
		reused_s1 <= spot_gone;
		reused_s2 <= reused_s1;
		reused_s3 <= reused_s2;
		reused_s4 <= reused_s3;
	end

	tpid_lane #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS),
		.POS_FRAC_BITS  (POS_FRAC_BITS)
	) u_lane_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.gains     (gains_q),
		.live      (live),
		.target    (tx),
		.spot      (sx),
		.spot_gone (spot_gone),
		.home      (home_x),
		.origin    (signed'(cfg_data)),
		.res       (lane_x)
	);

	tpid_lane #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS),
		.POS_FRAC_BITS  (POS_FRAC_BITS)
	) u_lane_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.gains     (gains_q),
		.live      (live),
		.target    (ty),
		.spot      (sy),
		.spot_gone (spot_gone),
		.home      (home_y),
		.origin    (signed'(cfg_data)),
		.res       (lane_y)
	);

	tpid_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.lane_x (lane_x),
		.lane_y (lane_y),
		.reused (reused_s4),
		.servo  (servo)
	);

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(FIFO_DEPTH))
		else $error("result credit count above queue depth");

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		lane_x.valid == lane_y.valid)
		else $error("axis lanes out of step");

	a_ignored_point: assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && !live && !out_beat) |=> $stable(cnt_q))
		else $error("ignored point changed the credit count");

	a_offer_credit: assert property (@(posedge clk) disable iff (!arst_n)
		servo.valid |-> (cnt_q != '0))
		else $error("result offered without an outstanding point");

endmodule

`default_nettype wire

FILE: test/testbench.sv
// Self-checking testbench for two_axis_incremental_pid_tracker: random and directed
// camera points, with an in-bench predictor of both incremental PID axes.
// Depends on tpid_pkg, tpid_stream_if and the tracker RTL.

module testbench;
	import tpid_pkg::*;

	localparam int COORD_BITS = 16;
	localparam int GAIN_FRAC = 14;
	localparam int POS_FRAC = 12;
	localparam int ROUND_SHIFT = GAIN_FRAC - POS_FRAC;
	localparam longint ROUND_HALF = longint'(1) <<< (ROUND_SHIFT - 1);
	localparam longint POS_LIM = longint'(1) <<< (19 + POS_FRAC);
	localparam int X_AXIS = 0;
	localparam int Y_AXIS = 1;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 12;
	localparam int RANDOM_PHASES = 6;
	localparam int POINTS_PER_PHASE = 200;
	localparam int CALM_PHASE = 2;
	localparam logic signed [FIELD_W-1:0] COORD_MAX = 16'sh7FFF;
	localparam logic signed [FIELD_W-1:0] COORD_MIN = 16'sh8000;
	localparam logic [GAIN_W-1:0] GAIN_MAX = 16'hFFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [GAIN_W-1:0] cfg_data = '0;
	bit calm = 1'b0;

	tpid_stream_if #(.T(in_beat_t)) points_ch ();
	tpid_stream_if #(.T(out_beat_t)) servo_ch ();

	two_axis_incremental_pid_tracker #(
		.COORD_WIDTH(COORD_BITS),
		.GAIN_FRAC_BITS(GAIN_FRAC),
		.POS_FRAC_BITS(POS_FRAC)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.points(points_ch),
		.servo(servo_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// tracker state mirror
	longint gain_p = KP_RESET;
	longint gain_i = KI_RESET;
	longint gain_d = KD_RESET;
	longint err1[2] = '{0, 0};
	longint err2[2] = '{0, 0};
	longint spot_last[2] = '{0, 0};
	longint servo_pos[2] = '{0, 0};

	in_beat_t pending_points[$];
	out_beat_t servo_expect[$];

	int errors = 0;
	int stall_cycles = 0;
	int point_beats = 0;
	int ignored_points = 0;
	int reused_spots = 0;
	int saturations = 0;
	int servo_checked = 0;
	int reg_writes = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
		logic signed [FIELD_W-1:0] coord;
		coord = val;
		case (idx)
			REG_GAIN_P: gain_p = val;
			REG_GAIN_I: gain_i = val;
			REG_GAIN_D: gain_d = val;
			REG_ORIGIN_X: begin
				spot_last[X_AXIS] = coord;
				servo_pos[X_AXIS] = longint'(coord) <<< POS_FRAC;
			end
			REG_ORIGIN_Y: begin
				spot_last[Y_AXIS] = coord;
				servo_pos[Y_AXIS] = longint'(coord) <<< POS_FRAC;
			end
			default: ;
		endcase
	endfunction

	task automatic track_point(input in_beat_t p);
		longint tgt[2];
		longint spt[2];
		longint err;
		longint acc;
		longint nxt;
		out_beat_t res;
		tgt[X_AXIS] = p.target_x;
		tgt[Y_AXIS] = p.target_y;
		spt[X_AXIS] = p.spot_x;
		spt[Y_AXIS] = p.spot_y;
		if (tgt[X_AXIS] == 0 && tgt[Y_AXIS] == 0) begin
			ignored_points++;
			return;
		end
		res.spot_reused = 1'b0;
		if (spt[X_AXIS] == 0 && spt[Y_AXIS] == 0) begin
			spt = spot_last;
			res.spot_reused = 1'b1;
			reused_spots++;
		end
		spot_last = spt;
		for (int a = X_AXIS; a <= Y_AXIS; a++) begin
			err = tgt[a] - spt[a];
			acc = gain_p * (err - err1[a]) + gain_i * err
				+ gain_d * (err - 2 * err1[a] + err2[a]);
			nxt = servo_pos[a] + ((acc + ROUND_HALF) >>> ROUND_SHIFT);
			err2[a] = err1[a];
			err1[a] = err;
			if (nxt < -POS_LIM) begin
				nxt = -POS_LIM;
				saturations++;
			end else if (nxt > POS_LIM - 1) begin
				nxt = POS_LIM - 1;
				saturations++;
			end
			servo_pos[a] = nxt;
		end
		res.servo_x = SERVO_W'(servo_pos[X_AXIS] >>> POS_FRAC);
		res.servo_y = SERVO_W'(servo_pos[Y_AXIS] >>> POS_FRAC);
		servo_expect.push_back(res);
	endtask

	function automatic logic signed [FIELD_W-1:0] rand_coord();
		case ($urandom_range(3))
			0: rand_coord = FIELD_W'($urandom);
			1: rand_coord = FIELD_W'(int'($urandom_range(600)) - 300);
			2: rand_coord = $urandom_range(1) ? COORD_MAX : COORD_MIN;
			default: rand_coord = FIELD_W'(int'($urandom_range(8000)) - 4000);
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] rand_gain();
		case ($urandom_range(4))
			0: rand_gain = '0;
			1: rand_gain = GAIN_MAX;
			2, 3: rand_gain = GAIN_W'($urandom_range(4095));
			default: rand_gain = GAIN_W'($urandom);
		endcase
	endfunction

	task automatic push_point(logic signed [FIELD_W-1:0] tx, logic signed [FIELD_W-1:0] ty,
			logic signed [FIELD_W-1:0] sx, logic signed [FIELD_W-1:0] sy);
		in_beat_t p;
		p.target_x = tx;
		p.target_y = ty;
		p.spot_x = sx;
		p.spot_y = sy;
		pending_points.push_back(p);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		apply_reg(idx, val);
		reg_writes++;
	endtask

	task automatic program_regs(logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
			logic [GAIN_W-1:0] kd, logic signed [FIELD_W-1:0] ox,
			logic signed [FIELD_W-1:0] oy, bit spare);
		write_reg(REG_GAIN_P, kp);
		write_reg(REG_GAIN_I, ki);
		write_reg(REG_GAIN_D, kd);
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		if (spare) begin
			for (int k = REG_ORIGIN_Y + 1; k < (1 << CFG_IDX_W); k++)
				write_reg(CFG_IDX_W'(k), GAIN_W'($urandom));
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (pending_points.size() != 0 || points_ch.valid || servo_expect.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// point driver
	always @(posedge clk) begin
		if (!arst_n) begin
			points_ch.valid <= 1'b0;
		end else if (!points_ch.valid || points_ch.ready) begin
			if (pending_points.size() != 0 && (calm || $urandom_range(99) >= 22)) begin
				points_ch.valid <= 1'b1;
				points_ch.data <= pending_points.pop_front();
			end else begin
				points_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			servo_ch.ready <= 1'b0;
		else
			servo_ch.ready <= calm || $urandom_range(99) >= 22;
	end

	always @(posedge clk) begin
		if (arst_n && points_ch.valid && points_ch.ready) begin
			point_beats++;
			track_point(points_ch.data);
		end
	end

	always @(posedge clk) begin : servo_monitor
		out_beat_t want;
		out_beat_t got;
		if (arst_n && servo_ch.valid && servo_ch.ready) begin
			got = servo_ch.data;
			if (servo_expect.size() == 0) begin
				$error("unexpected servo beat: servo_x %0d servo_y %0d spot_reused %0d",
					got.servo_x, got.servo_y, got.spot_reused);
				errors++;
			end else begin
				want = servo_expect.pop_front();
				servo_checked++;
				if (got.servo_x !== want.servo_x) begin
					$error("servo_x expected %0d actual %0d", want.servo_x, got.servo_x);
					errors++;
				end
				if (got.servo_y !== want.servo_y) begin
					$error("servo_y expected %0d actual %0d", want.servo_y, got.servo_y);
					errors++;
				end
				if (got.spot_reused !== want.spot_reused) begin
					$error("spot_reused expected %0d actual %0d",
						want.spot_reused, got.spot_reused);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((points_ch.valid && points_ch.ready) || (servo_ch.valid && servo_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int useful;
		in_beat_t p;
		points_ch.valid = 1'b0;
		points_ch.data = '0;
		servo_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset gains, homed at the origin
		push_point(16'sd100, -16'sd50, 16'sd0, 16'sd0);
		push_point(16'sd0, 16'sd0, 16'sd5, 16'sd5);
		push_point(16'sd0, 16'sd7, 16'sd3, 16'sd0);
		push_point(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
		push_point(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
		push_point(16'sd1, 16'sd1, 16'sd0, 16'sd0);
		push_point(-16'sd1, -16'sd1, -16'sd1, -16'sd1);
		wait_idle();

		// full gains from the far corners: drive both rails
		program_regs(GAIN_MAX, GAIN_MAX, GAIN_MAX, COORD_MAX, COORD_MIN, 1'b1);
		push_point(COORD_MIN, COORD_MAX, 16'sd0, 16'sd0);
		repeat (3) push_point(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
		repeat (3) push_point(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
		push_point(16'sd2, -16'sd3, 16'sd0, 16'sd0);
		wait_idle();

		// zero gains hold the servo at home
		program_regs('0, '0, '0, -16'sd1, 16'sd1, 1'b0);
		repeat (3) push_point(rand_coord(), rand_coord(), rand_coord(), rand_coord());
		wait_idle();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			program_regs(rand_gain(), rand_gain(), rand_gain(), rand_coord(), rand_coord(),
				ph == 0);
			calm = (ph == CALM_PHASE);
			useful = 0;
			while (useful < POINTS_PER_PHASE) begin
				p.target_x = rand_coord();
				p.target_y = rand_coord();
				p.spot_x = rand_coord();
				p.spot_y = rand_coord();
				case ($urandom_range(99)) inside
					[0:5]: begin
						p.target_x = '0;
						p.target_y = '0;
					end
					[6:21]: begin
						p.spot_x = '0;
						p.spot_y = '0;
					end
					default: ;
				endcase
				if (p.target_x != 0 || p.target_y != 0)
					useful++;
				pending_points.push_back(p);
			end
			wait_idle();
			calm = 1'b0;
		end

		$display("Covered %0d point beats (%0d with target at origin, %0d spot reuses),",
			point_beats, ignored_points, reused_spots);
		$display("%0d servo beats checked, %0d saturated axis updates, %0d register writes",
			servo_checked, saturations, reg_writes);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: two_axis_incremental_pid_tracker.f
hdl/tpid_pkg.sv
hdl/tpid_stream_if.sv
hdl/tpid_lane.sv
hdl/tpid_merge.sv
hdl/two_axis_incremental_pid_tracker.sv
test/testbench.sv
